// ----- design/eiuhp_pkg.sv -----
package eiuhp_pkg;

   localparam int unsigned EthHdrBytes = 14;
   localparam int unsigned IpMinBytes  = 20;
   localparam int unsigned UdpHdrBytes = 8;
   localparam int unsigned MinCapture  = EthHdrBytes + IpMinBytes + UdpHdrBytes;

   localparam logic [15:0] EtherTypeIpv4 = 16'h0800;
   localparam logic [7:0]  ProtoUdp      = 8'd17;
   localparam logic [3:0]  IpVersion4    = 4'd4;

   // fixed byte positions inside the frame
   localparam logic [15:0] OffCaptureCheck = 16'd0;
   localparam logic [15:0] OffTypeHigh     = 16'd12;
   localparam logic [15:0] OffTypeLow      = 16'd13;
   localparam logic [15:0] OffVersionIhl   = 16'd14;
   localparam logic [15:0] OffProtocol     = 16'd23;

   // byte positions inside the udp header
   localparam logic [15:0] RelSrcHigh = 16'd0;
   localparam logic [15:0] RelSrcLow  = 16'd1;
   localparam logic [15:0] RelDstHigh = 16'd2;
   localparam logic [15:0] RelDstLow  = 16'd3;
   localparam logic [15:0] RelLenHigh = 16'd4;
   localparam logic [15:0] RelLenLow  = 16'd5;

   typedef enum logic [1:0] {
      KIND_HEADER  = 2'd0,
      KIND_PAYLOAD = 2'd1,
      KIND_REJECT  = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      REASON_SHORT_CAPTURE = 3'd0,
      REASON_NOT_IPV4      = 3'd1,
      REASON_BAD_VER_IHL   = 3'd2,
      REASON_HDR_OVER_CAP  = 3'd3,
      REASON_NOT_UDP       = 3'd4,
      REASON_BAD_UDP_LEN   = 3'd5,
      REASON_ENDED_EARLY   = 3'd6
   } reason_type;

   typedef enum logic [1:0] {
      PHASE_HEADER  = 2'd0,
      PHASE_PAYLOAD = 2'd1,
      PHASE_IGNORE  = 2'd2
   } phase_type;

endpackage

// ----- design/ethernet_ipv4_udp_header_parser.sv -----
// channel   direction  handshake          payload
// req_      in         req_valid/ready    frame_byte, capture_length, frame_end
// rsp_      out        rsp_valid/ready    result_kind, ports, payload_length,
//                                         payload_byte, payload_last, reject_reason
//
// one frame byte is taken per cycle while req_ready is high; its result, if any, shows on rsp_ the next cycle.
// the parse state and the result register update in the same edge as the accept.
// req_ready stays high while the result register is empty or being drained,
// so a stall on rsp_ holds off req_ only while a result waits.
// synchronous reset returns the parser to the header phase at offset 0.
module ethernet_ipv4_udp_header_parser (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [7:0]             req_frame_byte,
   input  logic [15:0]            req_capture_length,
   input  logic                   req_frame_end,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output eiuhp_pkg::kind_type    rsp_result_kind,
   output logic [15:0]            rsp_source_port,
   output logic [15:0]            rsp_destination_port,
   output logic [15:0]            rsp_payload_length,
   output logic [7:0]             rsp_payload_byte,
   output logic                   rsp_payload_last,
   output eiuhp_pkg::reason_type  rsp_reject_reason
);
   import eiuhp_pkg::*;

   logic [15:0] offset_ff,     offset_in;
   logic [7:0]  type_high_ff,  type_high_in;
   logic [5:0]  ip_bytes_ff,   ip_bytes_in;
   logic [15:0] src_port_ff,   src_port_in;
   logic [15:0] dst_port_ff,   dst_port_in;
   logic [15:0] udp_len_ff,    udp_len_in;
   logic [15:0] remaining_ff,  remaining_in;
   phase_type   phase_ff,      phase_in;

   logic        rsp_valid_ff,  rsp_valid_in;
   kind_type    kind_ff,       kind_in;
   logic [15:0] out_src_ff,    out_src_in;
   logic [15:0] out_dst_ff,    out_dst_in;
   logic [15:0] out_len_ff,    out_len_in;
   logic [7:0]  out_byte_ff,   out_byte_in;
   logic        out_last_ff,   out_last_in;
   reason_type  reason_ff,     reason_in;

   logic accept;
   logic emit;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   always_comb begin
      logic        hit;
      reason_type  reason;
      logic        hdr_ok;
      logic [5:0]  ihl_bytes;
      logic [15:0] udp_start;
      logic [15:0] rel;
      logic [15:0] len_full;
      logic [15:0] rem_dec;
      logic        last;

      hit       = 1'b0;
      reason    = REASON_ENDED_EARLY;
      hdr_ok    = 1'b0;
      ihl_bytes = {req_frame_byte[3:0], 2'b00};
      udp_start = 16'(EthHdrBytes) + {10'd0, ip_bytes_ff};
      rel       = offset_ff - udp_start;
      len_full  = {udp_len_ff[15:8], req_frame_byte};
      rem_dec   = remaining_ff - 16'd1;
      last      = (rem_dec == 16'd0);

      offset_in    = offset_ff;
      type_high_in = type_high_ff;
      ip_bytes_in  = ip_bytes_ff;
      src_port_in  = src_port_ff;
      dst_port_in  = dst_port_ff;
      udp_len_in   = udp_len_ff;
      remaining_in = remaining_ff;
      phase_in     = phase_ff;

      emit        = 1'b0;
      kind_in     = KIND_REJECT;
      out_src_in  = 16'd0;
      out_dst_in  = 16'd0;
      out_len_in  = 16'd0;
      out_byte_in = 8'd0;
      out_last_in = 1'b0;
      reason_in   = REASON_SHORT_CAPTURE;

      if (accept) begin
         case (phase_ff)
            PHASE_HEADER: begin
               if (offset_ff == OffCaptureCheck && req_capture_length < 16'(MinCapture)) begin
                  hit    = 1'b1;
                  reason = REASON_SHORT_CAPTURE;
               end
               if (offset_ff == OffTypeHigh) begin
                  type_high_in = req_frame_byte;
               end
               if (offset_ff == OffTypeLow && {type_high_ff, req_frame_byte} != EtherTypeIpv4) begin
                  hit    = 1'b1;
                  reason = REASON_NOT_IPV4;
               end
               if (offset_ff == OffVersionIhl) begin
                  ip_bytes_in = ihl_bytes;
                  if (req_frame_byte[7:4] != IpVersion4 || ihl_bytes < 6'(IpMinBytes)) begin
                     hit    = 1'b1;
                     reason = REASON_BAD_VER_IHL;
                  end else if (req_capture_length <
                               16'(EthHdrBytes + UdpHdrBytes) + {10'd0, ihl_bytes}) begin
                     hit    = 1'b1;
                     reason = REASON_HDR_OVER_CAP;
                  end
               end
               if (offset_ff == OffProtocol && req_frame_byte != ProtoUdp) begin
                  hit    = 1'b1;
                  reason = REASON_NOT_UDP;
               end
               if (offset_ff > OffVersionIhl && offset_ff >= udp_start) begin
                  case (rel)
                     RelSrcHigh: src_port_in = {req_frame_byte, 8'd0};
                     RelSrcLow:  src_port_in = {src_port_ff[15:8], req_frame_byte};
                     RelDstHigh: dst_port_in = {req_frame_byte, 8'd0};
                     RelDstLow:  dst_port_in = {dst_port_ff[15:8], req_frame_byte};
                     RelLenHigh: udp_len_in  = {req_frame_byte, 8'd0};
                     RelLenLow: begin
                        udp_len_in = len_full;
                        if (len_full < 16'(UdpHdrBytes) ||
                            {1'b0, req_capture_length} <
                            {1'b0, udp_start} + {1'b0, len_full}) begin
                           hit    = 1'b1;
                           reason = REASON_BAD_UDP_LEN;
                        end else begin
                           hdr_ok = 1'b1;
                        end
                     end
                     default: ;
                  endcase
               end

               if (hit) begin
                  emit      = 1'b1;
                  kind_in   = KIND_REJECT;
                  reason_in = reason;
                  phase_in  = PHASE_IGNORE;
               end else if (req_frame_end) begin
                  emit      = 1'b1;
                  kind_in   = KIND_REJECT;
                  reason_in = REASON_ENDED_EARLY;
               end else if (hdr_ok) begin
                  remaining_in = len_full - 16'(UdpHdrBytes);
                  emit         = 1'b1;
                  kind_in      = KIND_HEADER;
                  out_src_in   = src_port_ff;
                  out_dst_in   = dst_port_ff;
                  out_len_in   = len_full - 16'(UdpHdrBytes);
                  phase_in     = (len_full != 16'(UdpHdrBytes)) ? PHASE_PAYLOAD : PHASE_IGNORE;
               end
            end
            PHASE_PAYLOAD: begin
               // checksum bytes sit between the length and the first payload byte
               if (offset_ff < udp_start + 16'(UdpHdrBytes)) begin
                  if (req_frame_end) begin
                     emit      = 1'b1;
                     kind_in   = KIND_REJECT;
                     reason_in = REASON_ENDED_EARLY;
                  end
               end else begin
                  remaining_in = rem_dec;
                  emit         = 1'b1;
                  if (req_frame_end && !last) begin
                     kind_in   = KIND_REJECT;
                     reason_in = REASON_ENDED_EARLY;
                  end else begin
                     kind_in     = KIND_PAYLOAD;
                     out_byte_in = req_frame_byte;
                     out_last_in = last;
                  end
                  if (last) begin
                     phase_in = PHASE_IGNORE;
                  end
               end
            end
            default: ;
         endcase

         if (req_frame_end) begin
            phase_in  = PHASE_HEADER;
            offset_in = 16'd0;
         end else if (offset_ff != 16'hFFFF) begin
            offset_in = offset_ff + 16'd1;
         end
      end

      rsp_valid_in = rsp_valid_ff;
      if (req_ready) begin
         rsp_valid_in = accept && emit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff    <= 16'd0;
         type_high_ff <= 8'd0;
         ip_bytes_ff  <= 6'd0;
         src_port_ff  <= 16'd0;
         dst_port_ff  <= 16'd0;
         udp_len_ff   <= 16'd0;
         remaining_ff <= 16'd0;
         phase_ff     <= PHASE_HEADER;
         rsp_valid_ff <= 1'b0;
      end else begin
         offset_ff    <= offset_in;
         type_high_ff <= type_high_in;
         ip_bytes_ff  <= ip_bytes_in;
         src_port_ff  <= src_port_in;
         dst_port_ff  <= dst_port_in;
         udp_len_ff   <= udp_len_in;
         remaining_ff <= remaining_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && emit) begin
         kind_ff     <= kind_in;
         out_src_ff  <= out_src_in;
         out_dst_ff  <= out_dst_in;
         out_len_ff  <= out_len_in;
         out_byte_ff <= out_byte_in;
         out_last_ff <= out_last_in;
         reason_ff   <= reason_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_result_kind      = kind_ff;
   assign rsp_source_port      = out_src_ff;
   assign rsp_destination_port = out_dst_ff;
   assign rsp_payload_length   = out_len_ff;
   assign rsp_payload_byte     = out_byte_ff;
   assign rsp_payload_last     = out_last_ff;
   assign rsp_reject_reason    = reason_ff;

endmodule

// ----- bench/tb_ethernet_ipv4_udp_header_parser.sv -----
module tb_ethernet_ipv4_udp_header_parser;
   import eiuhp_pkg::*;

   typedef struct packed {
      kind_type    kind;
      logic [15:0] sport;
      logic [15:0] dport;
      logic [15:0] plen;
      logic [7:0]  pbyte;
      logic        plast;
      reason_type  why;
   } parse_result_type;

   typedef struct packed {
      logic [7:0]  b;
      logic [15:0] cap;
      logic        fend;
      logic        drain;
      logic        hurry;
   } frame_item_type;

   localparam int unsigned MaxGap = 40;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_frame_byte = 8'h00;
   logic [15:0] req_capture_length = 16'h0000;
   logic        req_frame_end = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   kind_type    rsp_result_kind;
   logic [15:0] rsp_source_port;
   logic [15:0] rsp_destination_port;
   logic [15:0] rsp_payload_length;
   logic [7:0]  rsp_payload_byte;
   logic        rsp_payload_last;
   reason_type  rsp_reject_reason;

   ethernet_ipv4_udp_header_parser u_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_frame_byte       (req_frame_byte),
      .req_capture_length   (req_capture_length),
      .req_frame_end        (req_frame_end),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_result_kind      (rsp_result_kind),
      .rsp_source_port      (rsp_source_port),
      .rsp_destination_port (rsp_destination_port),
      .rsp_payload_length   (rsp_payload_length),
      .rsp_payload_byte     (rsp_payload_byte),
      .rsp_payload_last     (rsp_payload_last),
      .rsp_reject_reason    (rsp_reject_reason)
   );

   always #6 clock = ~clock;

   // parser state mirror
   logic [15:0] p_offset;
   logic [7:0]  p_type_hi;
   logic [5:0]  p_ihl_bytes;
   logic [15:0] p_src;
   logic [15:0] p_dst;
   logic [15:0] p_len;
   logic [15:0] p_left;
   phase_type   p_phase;

   frame_item_type   bytes_to_send[$];
   frame_item_type   sending;
   logic [7:0]       frame_buf[$];
   parse_result_type results_due[$];
   parse_result_type new_result;
   logic             new_result_valid = 1'b0;
   int unsigned      results_made = 0;
   int unsigned      results_seen = 0;
   int unsigned      send_gap = 0;
   int unsigned      hold_left = 0;
   int unsigned      hold_stage = 0;
   int unsigned      errors = 0;
   int unsigned      cycles = 0;
   int unsigned      limit_cycles = 100000;
   logic             quiet = 1'b0;

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      else if (r < 92) return $urandom_range(1, 3);
      else return $urandom_range(8, MaxGap);
   endfunction

   function automatic parse_result_type empty_result(kind_type k);
      parse_result_type r;
      r = '0;
      r.kind = k;
      return r;
   endfunction

   // advances the mirror by one frame byte, returns the result it causes if any
   task automatic parse_byte(input logic [7:0] b, input logic [15:0] cap, input logic fend,
                             output logic has, output parse_result_type r);
      logic        fail;
      logic        hdr_ok;
      logic        last;
      reason_type  why;
      int unsigned u;
      int unsigned rel;
      has = 1'b0;
      r = '0;
      fail = 1'b0;
      hdr_ok = 1'b0;
      why = REASON_SHORT_CAPTURE;
      case (p_phase)
         PHASE_HEADER: begin
            if (p_offset == OffCaptureCheck && cap < MinCapture) begin
               fail = 1'b1;
               why = REASON_SHORT_CAPTURE;
            end
            if (p_offset == OffTypeHigh) p_type_hi = b;
            if (p_offset == OffTypeLow && {p_type_hi, b} != EtherTypeIpv4) begin
               fail = 1'b1;
               why = REASON_NOT_IPV4;
            end
            if (p_offset == OffVersionIhl) begin
               p_ihl_bytes = {b[3:0], 2'b00};
               if (b[7:4] != IpVersion4 || {b[3:0], 2'b00} < IpMinBytes) begin
                  fail = 1'b1;
                  why = REASON_BAD_VER_IHL;
               end else if (int'(cap) < EthHdrBytes + int'({b[3:0], 2'b00}) + UdpHdrBytes) begin
                  fail = 1'b1;
                  why = REASON_HDR_OVER_CAP;
               end
            end
            if (p_offset == OffProtocol && b != ProtoUdp) begin
               fail = 1'b1;
               why = REASON_NOT_UDP;
            end
            if (p_offset > OffVersionIhl) begin
               u = EthHdrBytes + p_ihl_bytes;
               if (p_offset >= u) begin
                  rel = p_offset - u;
                  case (rel)
                     RelSrcHigh: p_src = {b, 8'h00};
                     RelSrcLow:  p_src[7:0] = b;
                     RelDstHigh: p_dst = {b, 8'h00};
                     RelDstLow:  p_dst[7:0] = b;
                     RelLenHigh: p_len = {b, 8'h00};
                     RelLenLow: begin
                        p_len[7:0] = b;
                        if (p_len < UdpHdrBytes || int'(cap) < u + p_len) begin
                           fail = 1'b1;
                           why = REASON_BAD_UDP_LEN;
                        end else begin
                           hdr_ok = 1'b1;
                        end
                     end
                     default: ;
                  endcase
               end
            end
            if (fail) begin
               has = 1'b1;
               r = empty_result(KIND_REJECT);
               r.why = why;
               p_phase = PHASE_IGNORE;
            end else if (fend) begin
               has = 1'b1;
               r = empty_result(KIND_REJECT);
               r.why = REASON_ENDED_EARLY;
            end else if (hdr_ok) begin
               p_left = p_len - 16'(UdpHdrBytes);
               has = 1'b1;
               r = empty_result(KIND_HEADER);
               r.sport = p_src;
               r.dport = p_dst;
               r.plen = p_left;
               p_phase = (p_left != 0) ? PHASE_PAYLOAD : PHASE_IGNORE;
            end
         end
         PHASE_PAYLOAD: begin
            u = EthHdrBytes + p_ihl_bytes + UdpHdrBytes;
            if (p_offset < u) begin
               // still in the udp checksum bytes
               if (fend) begin
                  has = 1'b1;
                  r = empty_result(KIND_REJECT);
                  r.why = REASON_ENDED_EARLY;
               end
            end else begin
               p_left = p_left - 16'd1;
               last = (p_left == 0);
               has = 1'b1;
               if (fend && !last) begin
                  r = empty_result(KIND_REJECT);
                  r.why = REASON_ENDED_EARLY;
               end else begin
                  r = empty_result(KIND_PAYLOAD);
                  r.pbyte = b;
                  r.plast = last;
               end
               if (last) p_phase = PHASE_IGNORE;
            end
         end
         default: ;
      endcase
      if (fend) begin
         p_phase = PHASE_HEADER;
         p_offset = 16'd0;
      end else if (p_offset != 16'hFFFF) begin
         p_offset = p_offset + 16'd1;
      end
   endtask

   task automatic start_udp(input int unsigned ihl, input logic [15:0] udp_len,
                            input int unsigned pay_n, input logic [15:0] sp,
                            input logic [15:0] dp);
      frame_buf.delete();
      repeat (12) frame_buf.push_back(8'($urandom));
      frame_buf.push_back(EtherTypeIpv4[15:8]);
      frame_buf.push_back(EtherTypeIpv4[7:0]);
      frame_buf.push_back({IpVersion4, 4'(ihl)});
      // protocol sits nine bytes into the ip header
      for (int i = 1; i < ihl * 4; i++) frame_buf.push_back((i == 9) ? ProtoUdp : 8'($urandom));
      frame_buf.push_back(sp[15:8]);
      frame_buf.push_back(sp[7:0]);
      frame_buf.push_back(dp[15:8]);
      frame_buf.push_back(dp[7:0]);
      frame_buf.push_back(udp_len[15:8]);
      frame_buf.push_back(udp_len[7:0]);
      repeat (2) frame_buf.push_back(8'($urandom));
      repeat (pay_n) frame_buf.push_back(8'($urandom));
   endtask

   task automatic trim(input int unsigned n);
      while (frame_buf.size() > n) void'(frame_buf.pop_back());
   endtask

   task automatic push_frame(input logic [15:0] cap, input logic drain, input logic hurry);
      frame_item_type it;
      foreach (frame_buf[i]) begin
         it.b = frame_buf[i];
         it.cap = cap;
         it.fend = (i == frame_buf.size() - 1);
         it.drain = drain && (i == 0);
         it.hurry = hurry;
         bytes_to_send.push_back(it);
      end
   endtask

   task automatic add_random_frame();
      int unsigned pick;
      int unsigned ihl;
      int unsigned u;
      int unsigned pay;
      int unsigned ulen;
      int unsigned need;
      int unsigned fail_at;
      int unsigned v;
      logic [15:0] cap;
      logic [15:0] t;
      logic [7:0]  hb;
      pick = $urandom_range(0, 99);
      ihl = ($urandom_range(0, 3) == 0) ? $urandom_range(6, 15) : 5;
      u = EthHdrBytes + ihl * 4;
      pay = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 120) : $urandom_range(0, 16);
      ulen = pay + UdpHdrBytes;
      need = u + ulen;
      fail_at = 0;
      start_udp(ihl, 16'(ulen), pay, 16'($urandom), 16'($urandom));
      if ($urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 4)) frame_buf.push_back(8'($urandom));
      case ($urandom_range(0, 9))
         0:       cap = 16'hFFFF;
         1:       cap = 16'($urandom_range(need, 65535));
         2, 3, 4: cap = 16'(need + $urandom_range(1, 20));
         default: cap = 16'(need);
      endcase
      if (pick < 60) begin
         // well-formed as built
      end else if (pick < 72) begin
         trim($urandom_range(1, frame_buf.size() - 1));
      end else if (pick < 90) begin
         case ($urandom_range(0, 6))
            0: begin
               cap = 16'($urandom_range(0, MinCapture - 1));
               fail_at = OffCaptureCheck;
            end
            1: begin
               t = 16'($urandom);
               if (t == EtherTypeIpv4) t = 16'h86DD;
               frame_buf[OffTypeHigh] = t[15:8];
               frame_buf[OffTypeLow] = t[7:0];
               fail_at = OffTypeLow;
            end
            2: begin
               v = $urandom_range(0, 15);
               if (v == IpVersion4) v = 15;
               hb = frame_buf[OffVersionIhl];
               frame_buf[OffVersionIhl] = {4'(v), hb[3:0]};
               fail_at = OffVersionIhl;
            end
            3: begin
               v = $urandom_range(0, 4);
               hb = frame_buf[OffVersionIhl];
               frame_buf[OffVersionIhl] = {hb[7:4], 4'(v)};
               fail_at = OffVersionIhl;
            end
            4: begin
               v = $urandom_range(6, 15);
               hb = frame_buf[OffVersionIhl];
               frame_buf[OffVersionIhl] = {hb[7:4], 4'(v)};
               cap = 16'($urandom_range(MinCapture, EthHdrBytes + v * 4 + UdpHdrBytes - 1));
               fail_at = OffVersionIhl;
            end
            5: begin
               hb = 8'($urandom);
               if (hb == ProtoUdp) hb = 8'd6;
               frame_buf[OffProtocol] = hb;
               fail_at = OffProtocol;
            end
            default: begin
               if (pay > 0 && $urandom_range(0, 1) == 1) begin
                  cap = 16'($urandom_range(u + UdpHdrBytes, need - 1));
               end else begin
                  frame_buf[u + RelLenHigh] = 8'h00;
                  frame_buf[u + RelLenLow] = 8'($urandom_range(0, UdpHdrBytes - 1));
               end
               fail_at = u + RelLenLow;
            end
         endcase
         trim(fail_at + 1 + $urandom_range(0, 3));
      end else begin
         frame_buf.delete();
         repeat ($urandom_range(1, 60)) frame_buf.push_back(8'($urandom));
         cap = 16'($urandom);
      end
      push_frame(cap, $urandom_range(0, 11) == 0, 1'b0);
   endtask

   // sender
   always @(posedge clock) begin : drive
      logic             nv;
      logic             has;
      parse_result_type made;
      if (reset) begin
         req_valid <= 1'b0;
         new_result_valid <= 1'b0;
         send_gap = 0;
         p_offset = '0;
         p_type_hi = '0;
         p_ihl_bytes = '0;
         p_src = '0;
         p_dst = '0;
         p_len = '0;
         p_left = '0;
         p_phase = PHASE_HEADER;
      end else begin
         nv = req_valid;
         has = 1'b0;
         made = '0;
         if (req_valid && req_ready) begin
            parse_byte(sending.b, sending.cap, sending.fend, has, made);
            if (has) results_made++;
            nv = 1'b0;
         end
         if (!nv) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (bytes_to_send.size() > 0 &&
                         (!bytes_to_send[0].drain || results_seen >= results_made)) begin
               sending = bytes_to_send.pop_front();
               req_frame_byte <= sending.b;
               req_capture_length <= sending.cap;
               req_frame_end <= sending.fend;
               nv = 1'b1;
               send_gap = (sending.hurry || quiet) ? 0 : pick_gap();
            end
         end
         req_valid <= nv;
         new_result_valid <= has;
         new_result <= made;
      end
   end

   // receiver backpressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left = 0;
      end else begin
         if (hold_stage == 0 && results_seen >= 30) begin
            hold_stage = 1;
            hold_left = 400;
         end else if (hold_stage == 1 && results_seen >= 120) begin
            hold_stage = 2;
            hold_left = 400;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (quiet || $urandom_range(0, 99) < 65) begin
            rsp_ready <= 1'b1;
         end else begin
            hold_left = pick_gap();
            rsp_ready <= 1'b0;
         end
      end
   end

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
   endtask

   // result checker
   always @(posedge clock) begin : watch
      parse_result_type want;
      if (reset) begin
         results_due.delete();
         results_seen <= 0;
      end else begin
         if (new_result_valid) results_due.push_back(new_result);
         if (rsp_valid && rsp_ready) begin
            results_seen <= results_seen + 1;
            if (results_due.size() == 0) begin
               errors++;
               $display("%0t: unexpected result, expected none, actual kind %0d",
                        $time, rsp_result_kind);
            end else begin
               want = results_due.pop_front();
               check_field("result_kind", 16'(want.kind), 16'(rsp_result_kind));
               check_field("source_port", want.sport, rsp_source_port);
               check_field("destination_port", want.dport, rsp_destination_port);
               check_field("payload_length", want.plen, rsp_payload_length);
               check_field("payload_byte", 16'(want.pbyte), 16'(rsp_payload_byte));
               check_field("payload_last", 16'(want.plast), 16'(rsp_payload_last));
               check_field("reject_reason", 16'(want.why), 16'(rsp_reject_reason));
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if ($urandom_range(0, 299) == 0) quiet <= !quiet;
      if (cycles > limit_cycles) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      int unsigned mark;
      // one byte, short capture flagged on the final byte
      frame_buf.delete();
      frame_buf.push_back(8'hFF);
      push_frame(16'd0, 1'b0, 1'b0);
      // short capture, rest ignored
      frame_buf.delete();
      repeat (3) frame_buf.push_back(8'($urandom));
      push_frame(16'(MinCapture - 1), 1'b0, 1'b0);
      // ends long before the header
      start_udp(5, 16'd8, 0, 16'h1234, 16'h5678);
      trim(6);
      push_frame(16'(MinCapture), 1'b0, 1'b0);
      // wrong ethertype on the final byte
      start_udp(5, 16'd8, 0, 16'h1234, 16'h5678);
      frame_buf[OffTypeHigh] = 8'h86;
      frame_buf[OffTypeLow] = 8'hDD;
      trim(OffTypeLow + 1);
      push_frame(16'(MinCapture), 1'b0, 1'b0);
      // version 6
      start_udp(5, 16'd8, 0, 16'h1234, 16'h5678);
      frame_buf[OffVersionIhl] = 8'h65;
      trim(20);
      push_frame(16'(MinCapture), 1'b0, 1'b0);
      // ihl 4
      start_udp(5, 16'd8, 0, 16'h1234, 16'h5678);
      frame_buf[OffVersionIhl] = 8'h44;
      trim(20);
      push_frame(16'(MinCapture), 1'b0, 1'b0);
      // largest ihl, capture one short of the headers
      start_udp(15, 16'd8, 0, 16'h1234, 16'h5678);
      trim(16);
      push_frame(16'(EthHdrBytes + 60 + UdpHdrBytes - 1), 1'b0, 1'b0);
      // not udp
      start_udp(5, 16'd8, 0, 16'h1234, 16'h5678);
      frame_buf[OffProtocol] = 8'd6;
      push_frame(16'(MinCapture), 1'b0, 1'b0);
      // udp length 7, failing on the final byte
      start_udp(5, 16'd7, 0, 16'h1234, 16'h5678);
      trim(40);
      push_frame(16'(MinCapture), 1'b0, 1'b0);
      // udp length over capture
      start_udp(5, 16'd20, 12, 16'h1234, 16'h5678);
      push_frame(16'd53, 1'b0, 1'b0);
      // udp length exactly 8: header only, after all earlier results are in
      start_udp(5, 16'd8, 0, 16'hFFFF, 16'h0000);
      push_frame(16'(MinCapture), 1'b1, 1'b0);
      // ends on the byte that would give the header
      start_udp(5, 16'd8, 0, 16'hA5A5, 16'h5A5A);
      trim(40);
      push_frame(16'(MinCapture), 1'b0, 1'b0);
      // ends in the checksum with payload due
      start_udp(5, 16'd12, 4, 16'h0102, 16'h0304);
      trim(41);
      push_frame(16'd46, 1'b0, 1'b0);
      // ends before the last payload byte
      start_udp(5, 16'd12, 4, 16'h0506, 16'h0708);
      trim(44);
      push_frame(16'd46, 1'b0, 1'b0);
      // full payload with trailing bytes, largest capture
      start_udp(6, 16'd13, 5, 16'h0000, 16'hFFFF);
      frame_buf[46] = 8'h00;
      frame_buf[47] = 8'hFF;
      repeat (3) frame_buf.push_back(8'($urandom));
      push_frame(16'hFFFF, 1'b0, 1'b0);
      // frame ends exactly on the last payload byte
      start_udp(5, 16'd9, 1, 16'h8000, 16'h0001);
      push_frame(16'd43, 1'b0, 1'b0);

      mark = bytes_to_send.size();
      while (bytes_to_send.size() < mark + 970) add_random_frame();

      limit_cycles = bytes_to_send.size() * 3 * (2 * MaxGap + 4) + 20000;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (bytes_to_send.size() != 0 || req_valid) @(negedge clock);
      while (results_seen < results_made) @(negedge clock);
      repeat (16) @(negedge clock);
      if (errors == 0 && results_seen == results_made) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
